/* hw/rtl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window median unit.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned Window  = 16;

  typedef logic signed [SampleW-1:0] sample_t;

  // What one cell shows its neighbors
  typedef struct packed {
    sample_t value;
    logic    gt;
    logic    valid;
  } nbr_t;

endpackage

/* hw/rtl/swm_sample_if.sv */
// ----------------------------------------------------------------------------
// swm_sample_if
// Valid/ready channel carrying one sensor sample per beat.
// ----------------------------------------------------------------------------
interface swm_sample_if;
  logic            valid;
  logic            ready;
  swm_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* hw/rtl/swm_median_if.sv */
// ----------------------------------------------------------------------------
// swm_median_if
// Valid/ready channel carrying one median result per beat.
// ----------------------------------------------------------------------------
interface swm_median_if;
  logic            valid;
  logic            ready;
  swm_pkg::sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

/* hw/rtl/swm_cell.sv */
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: holds a sample and its age, and on each
// accepted sample takes its next value from itself, a neighbor or the sample.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int unsigned AGE_W  = 4,
  parameter int unsigned OLDEST = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                full_i,
  input  swm_pkg::sample_t    sample_i,
  input  swm_pkg::nbr_t       left_i,
  input  logic [AGE_W-1:0]    left_age_i,
  input  swm_pkg::nbr_t       right_i,
  input  logic [AGE_W-1:0]    right_age_i,
  input  logic                del_i,
  output swm_pkg::nbr_t       self_o,
  output logic [AGE_W-1:0]    age_o,
  output logic                del_o,
  output swm_pkg::sample_t    value_d_o
);

  swm_pkg::sample_t value_q, value_d;
  logic [AGE_W-1:0] age_q, age_d;
  logic             valid_q, valid_d;
  logic             gt_self;
  logic             hit;

  assign gt_self = !valid_q || (value_q > sample_i);
  assign hit     = full_i ? (valid_q && (age_q == AGE_W'(OLDEST)))
                          : (!valid_q && left_i.valid);

  always_comb begin
    value_d = value_q;
    age_d   = age_q + AGE_W'(1);
    if (del_i) begin
      if (!right_i.gt) begin
        value_d = right_i.value;
        age_d   = right_age_i + AGE_W'(1);
      end else if (!gt_self) begin
        value_d = sample_i;
        age_d   = '0;
      end
    end else if (hit) begin
      if (!right_i.gt) begin
        value_d = right_i.value;
        age_d   = right_age_i + AGE_W'(1);
      end else if (!left_i.gt) begin
        value_d = sample_i;
        age_d   = '0;
      end else begin
        value_d = left_i.value;
        age_d   = left_age_i + AGE_W'(1);
      end
    end else if (gt_self) begin
      if (!left_i.gt) begin
        value_d = sample_i;
        age_d   = '0;
      end else begin
        value_d = left_i.value;
        age_d   = left_age_i + AGE_W'(1);
      end
    end
  end

  assign valid_d = valid_q | hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

  assign self_o.value = value_q;
  assign self_o.gt    = gt_self;
  assign self_o.valid = valid_q;
  assign age_o        = age_q;
  assign del_o        = del_i | hit;
  assign value_d_o    = value_d;

endmodule

/* hw/rtl/sliding_window_median_unit.sv */
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Running median over the last WINDOW signed 24-bit samples.
// ----------------------------------------------------------------------------
// The window is kept as a row of WINDOW cells sorted ascending; each accepted
// sample drops the oldest entry (once the window is full) and is inserted in
// order in the same cycle, so one sample is accepted every clock while input
// ready is high, and its median appears on the output in the cycle after
// acceptance. The median is the entry at sorted position count/2 of the valid
// entries (upper median for an even count), picked from the cells' next
// values into an output register. Throughput is set by the combinational
// insert and delete across the cell row; input ready drops only while a
// result waits in the output register and the output side is not ready.
// Reset empties the window at once, with no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_median_unit #(
  parameter int unsigned WINDOW = swm_pkg::Window
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  swm_sample_if.sink          sample_ch,
  swm_median_if.source        median_ch
);

  localparam int unsigned AgeW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned IdxW = AgeW;
  localparam int unsigned CntW = $clog2(WINDOW + 1);

  swm_pkg::nbr_t    cell_nbr [WINDOW];
  logic [AgeW-1:0]  cell_age [WINDOW];
  swm_pkg::sample_t cell_nxt [WINDOW];
  logic [WINDOW:0]  del_chain;
  logic [WINDOW-1:0] vld_vec;

  logic             accept;
  logic             full;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  sel_idx;
  swm_pkg::sample_t median_q;
  logic             out_vld_q;
  logic             sorted_ok;

  assign sample_ch.ready = !out_vld_q || median_ch.ready;
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign full            = (cnt_q == CntW'(WINDOW));
  assign cnt_d           = full ? cnt_q : cnt_q + CntW'(1);
  assign sel_idx         = IdxW'(cnt_d >> 1);
  assign del_chain[0]    = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    swm_pkg::nbr_t   left_nbr, right_nbr;
    logic [AgeW-1:0] left_age, right_age;

    if (i == 0) begin : g_first
      assign left_nbr = '{value: '0, gt: 1'b0, valid: 1'b1};
      assign left_age = '0;
    end else begin : g_mid_l
      assign left_nbr = cell_nbr[i-1];
      assign left_age = cell_age[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign right_nbr = '{value: '0, gt: 1'b1, valid: 1'b0};
      assign right_age = '0;
    end else begin : g_mid_r
      assign right_nbr = cell_nbr[i+1];
      assign right_age = cell_age[i+1];
    end

    swm_cell #(
      .AGE_W  (AgeW),
      .OLDEST (WINDOW - 1)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (accept),
      .full_i      (full),
      .sample_i    (sample_ch.sample),
      .left_i      (left_nbr),
      .left_age_i  (left_age),
      .right_i     (right_nbr),
      .right_age_i (right_age),
      .del_i       (del_chain[i]),
      .self_o      (cell_nbr[i]),
      .age_o       (cell_age[i]),
      .del_o       (del_chain[i+1]),
      .value_d_o   (cell_nxt[i])
    );

    assign vld_vec[i] = cell_nbr[i].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
      end else if (median_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      median_q <= cell_nxt[sel_idx];
    end
  end

  assign median_ch.valid  = out_vld_q;
  assign median_ch.median = median_q;

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < WINDOW - 1; i++) begin
      if (vld_vec[i+1] && (cell_nbr[i].value > cell_nbr[i+1].value)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) == int'(cnt_q))
    else $error("valid cells disagree with fill count");

  a_row_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sorted_ok)
    else $error("cell row out of order");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> median_ch.valid)
    else $error("accepted sample produced no result");

  a_thermometer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_vec[0] || (vld_vec == '0))
    else $error("valid cells not packed at the low end");

endmodule

/* tb/swm_median_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_median_checker
// Watches the sample and median channels of the sliding window median unit,
// keeps its own copy of the window, and compares every median beat against
// the running upper median of the last Window samples accepted.
// ----------------------------------------------------------------------------
module swm_median_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  swm_sample_if       sample_ch,
  swm_median_if       median_ch,
  output int unsigned mismatch_count_o,
  output int unsigned pending_medians_o
);

  swm_pkg::sample_t window_q [swm_pkg::Window];
  int unsigned      wr_ptr_q;
  int unsigned      fill_q;
  swm_pkg::sample_t pending_medians_q [$];

  function automatic swm_pkg::sample_t upper_median(input int unsigned cnt);
    swm_pkg::sample_t sorted [swm_pkg::Window];
    swm_pkg::sample_t key;
    int               j;
    for (int i = 0; i < cnt; i++) sorted[i] = window_q[i];
    for (int i = 1; i < cnt; i++) begin
      key = sorted[i];
      j   = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    return sorted[cnt/2];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    swm_pkg::sample_t want;
    if (!rst_ni) begin
      foreach (window_q[i]) window_q[i] = '0;
      wr_ptr_q = 0;
      fill_q   = 0;
      pending_medians_q.delete();
      mismatch_count_o  = 0;
      pending_medians_o = 0;
    end else begin
      if (median_ch.valid && median_ch.ready) begin
        if (pending_medians_q.size() == 0) begin
          $display("%0t: median beat with nothing pending, expected none, actual %0d",
                   $time, median_ch.median);
          mismatch_count_o++;
        end else begin
          want = pending_medians_q.pop_front();
          if (median_ch.median !== want) begin
            $display("%0t: median mismatch, expected %0d, actual %0d",
                     $time, want, median_ch.median);
            mismatch_count_o++;
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        window_q[wr_ptr_q] = sample_ch.sample;
        wr_ptr_q = (wr_ptr_q == swm_pkg::Window - 1) ? 0 : wr_ptr_q + 1;
        if (fill_q < swm_pkg::Window) fill_q++;
        pending_medians_q.push_back(upper_median(fill_q));
      end
      pending_medians_o = pending_medians_q.size();
    end
  end

endmodule

/* tb/tb_sliding_window_median_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median_unit
// Drives sensor samples into the sliding window median unit with random
// gaps and output stalls, including one long output hold-off, and reports
// the verdict from the median checker.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_unit;

  localparam int NumDirected = 22;
  localparam int DirectedVals [NumDirected] = '{
    8388607, -8388608, 0, -1, 1, 8388607, -8388608, 5, 5, 5, -8388607,
    8388606, 2, -2, 0, 0, 1048576, -1048576, 5592405, -5592406, 7, -7
  };
  localparam int PhaseItems   = 250;
  localparam int HoldOffItems = 80;
  localparam int HoldOffLen   = 300;

  logic clk_i;
  logic rst_ni;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_req;
  int unsigned mismatch_count;
  int unsigned pending_medians;

  swm_sample_if sample_ch ();
  swm_median_if median_ch ();

  sliding_window_median_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_ch (sample_ch),
    .median_ch (median_ch)
  );

  swm_median_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sample_ch         (sample_ch),
    .median_ch         (median_ch),
    .mismatch_count_o  (mismatch_count),
    .pending_medians_o (pending_medians)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic int unsigned draw_gap(input int unsigned pct);
    if (pct != 0 && $urandom_range(0, 99) < pct) return $urandom_range(0, 10);
    return 0;
  endfunction

  function automatic swm_pkg::sample_t draw_sample();
    case ($urandom_range(0, 3))
      0:       return swm_pkg::sample_t'($urandom_range(0, 8)) - swm_pkg::sample_t'(4);
      1:       return $urandom_range(0, 1) ? swm_pkg::sample_t'(8388607)
                                           : swm_pkg::sample_t'(-8388608);
      default: return swm_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after the beat.
  task automatic push_sample(input swm_pkg::sample_t s);
    int unsigned gap;
    gap = draw_gap(send_idle_pct);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk_i); while (!(sample_ch.valid && sample_ch.ready));
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    bit          hold_off_done;
    hold_off_done = 1'b0;
    median_ch.ready <= 1'b0;
    @(negedge clk_i);
    forever begin
      stall = draw_gap(recv_idle_pct);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        stall = HoldOffLen;
      end
      if (stall > 0) begin
        median_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      median_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(median_ch.valid && median_ch.ready));
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned send_pcts [6];
    int unsigned recv_pcts [6];
    send_pcts = '{0, 100, 0, 50, 100, 30};
    recv_pcts = '{0, 0, 100, 50, 100, 70};
    rst_ni           = 1'b0;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    send_idle_pct    = 30;
    recv_idle_pct    = 30;
    hold_off_req     = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      push_sample(swm_pkg::sample_t'(DirectedVals[i]));
    end

    // hold the output side off while samples keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 1'b1;
    for (int i = 0; i < HoldOffItems; i++) push_sample(draw_sample());

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = send_pcts[p];
      recv_idle_pct = recv_pcts[p];
      for (int i = 0; i < PhaseItems; i++) push_sample(draw_sample());
    end
    sample_ch.valid <= 1'b0;

    while (pending_medians != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
